// ===== hw/rtl/rbd_pkg.sv =====
// Shared types and constants for the ring buffer deque.
// Used by the channel interfaces and every module of the block; depends on nothing.
package rbd_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;
	localparam int VAL_W      = 32;
	localparam int WIDE_W     = 64;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CNT_W      = 5;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Memory strobes from the pointer logic to the entry store
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

	// Per-word result info carried alongside the pending memory read
	typedef struct packed {
		logic             pop;
		status_t          status;
		logic [CNT_W-1:0] fill;
	} s1_info_t;

endpackage

// ===== hw/rtl/rbd_if.sv =====
// Channel interfaces of the ring buffer deque: request, response and configuration.
// Depends on rbd_pkg for field widths.
interface rbd_req_if import rbd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [VAL_W-1:0]  push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface rbd_rsp_if import rbd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  popped_value;
	logic [STAT_W-1:0]        status;
	logic [CNT_W-1:0]         fill_level;

	modport source (output valid, output popped_value, output status, output fill_level,
		input ready);
	modport sink   (input valid, input popped_value, input status, input fill_level,
		output ready);
endinterface

interface rbd_cfg_if import rbd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

// ===== hw/rtl/rbd_store.sv =====
// Entry store of the ring buffer deque: one write or one registered read per cycle.
// Depends on rbd_pkg for the memory command struct.
module rbd_store import rbd_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  mem_cmd_t              cmd,
	input  logic [AW-1:0]         addr,
	input  logic [DATA_WIDTH-1:0] wdata,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// Write the pushed word
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
	end

	// Register the read word; hold it until the next read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/rbd_ctrl.sv =====
// Pointer and count logic of the ring buffer deque: capacity register, head, fill
// count, slot computation and memory strobes. Depends on rbd_pkg and rbd_if.
module rbd_ctrl import rbd_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rbd_req_if.sink               req,
	rbd_cfg_if.sink               cfg,
	input  logic                  slot_free,
	output mem_cmd_t              mem_cmd,
	output logic [AW-1:0]         mem_addr,
	output logic [DATA_WIDTH-1:0] mem_wdata,
	output logic                  launch,
	output s1_info_t              launch_info
);

	function automatic logic [CNT_W-1:0] clip_cap(input logic [CNT_W-1:0] c);
		if (c == '0) begin
			return CNT_W'(1);
		end else if (int'(c) > DEPTH) begin
			return CNT_W'(DEPTH);
		end else begin
			return c;
		end
	endfunction

	logic [CNT_W-1:0] eff_cap_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	action_t          act;
	logic             is_push;
	logic             full;
	logic             empty;
	logic             ok;
	logic [CNT_W-1:0] offset;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] slot;
	logic [CNT_W:0]   head_inc;
	logic [CNT_W-1:0] head_next;
	logic [CNT_W-1:0] count_next;

	assign act     = action_t'(req.action);
	assign is_push = (act == ACT_PUSH_FRONT) || (act == ACT_PUSH_BACK);
	assign full    = (count_q == eff_cap_q);
	assign empty   = (count_q == '0);
	assign ok      = is_push ? !full : !empty;

	// Pick the ring offset from head for this action
	always_comb begin
		unique case (act)
			ACT_PUSH_FRONT: offset = eff_cap_q - CNT_W'(1);
			ACT_PUSH_BACK:  offset = count_q;
			ACT_POP_FRONT:  offset = '0;
			ACT_POP_BACK:   offset = count_q - CNT_W'(1);
			default:        offset = '0;
		endcase
	end

	// Wrap head + offset once; both terms stay below capacity whenever the operation is carried out
	assign sum  = {1'b0, head_q} + {1'b0, offset};
	assign slot = (sum >= {1'b0, eff_cap_q}) ? CNT_W'(sum - {1'b0, eff_cap_q})
		: CNT_W'(sum);

	// Advance head past the front word on a front pop
	assign head_inc = {1'b0, head_q} + (CNT_W+1)'(1);

	always_comb begin
		head_next = head_q;
		if (act == ACT_PUSH_FRONT) begin
			head_next = slot;
		end else if (act == ACT_POP_FRONT) begin
			head_next = (head_inc == {1'b0, eff_cap_q}) ? '0 : CNT_W'(head_inc);
		end
	end

	assign count_next = is_push ? count_q + CNT_W'(1) : count_q - CNT_W'(1);

	// Handshakes and memory strobes
	assign req.ready = slot_free;
	assign cfg.ready = 1'b1;
	assign launch    = req.valid && req.ready;

	assign mem_cmd.wr = launch && is_push && !full;
	assign mem_cmd.rd = launch && !is_push && !empty;
	assign mem_addr   = AW'(slot);
	assign mem_wdata  = DATA_WIDTH'($unsigned(req.push_value));

	// Result info for the word being launched
	always_comb begin
		launch_info.pop = !is_push && !empty;
		if (ok) begin
			launch_info.status = STAT_DONE;
		end else if (is_push) begin
			launch_info.status = STAT_FULL;
		end else begin
			launch_info.status = STAT_EMPTY;
		end
		launch_info.fill = ok ? count_next : count_q;
	end

	// Hold capacity, head and count; a capacity write empties the deque
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_cap_q <= clip_cap(CAP_RESET);
			head_q    <= '0;
			count_q   <= '0;
		end else if (cfg.valid) begin
			eff_cap_q <= clip_cap(cfg.capacity);
			head_q    <= '0;
			count_q   <= '0;
		end else if (launch && ok) begin
			head_q    <= head_next;
			count_q   <= count_next;
		end
	end

	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_cap_q)
		else $error("fill count exceeds capacity");

	a_head_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < eff_cap_q)
		else $error("head index outside ring");

endmodule

// ===== hw/rtl/rbd_out.sv =====
// Result stage of the ring buffer deque: tracks the word waiting on its memory read
// and holds the response register. Depends on rbd_pkg and rbd_if.
module rbd_out import rbd_pkg::*; #(
	parameter int DATA_WIDTH = DATA_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  launch,
	input  s1_info_t              launch_info,
	input  logic [DATA_WIDTH-1:0] rdata,
	output logic                  slot_free,
	rbd_rsp_if.source             rsp
);

	logic                    v_s1;
	s1_info_t                info_s1;
	logic                    out_valid_q;
	logic [VAL_W-1:0]        popped_q;
	status_t                 status_q;
	logic [CNT_W-1:0]        fill_q;
	logic                    adv;
	logic [WIDE_W-1:0]       rd_wide;

	assign adv       = !out_valid_q || rsp.ready;
	assign slot_free = !v_s1 || adv;
	assign rd_wide   = WIDE_W'(rdata);

	// Track the word whose read data lands next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= launch || (v_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			info_s1 <= launch_info;
		end
	end

	// Load the response register when it is free or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			popped_q <= info_s1.pop ? rd_wide[VAL_W-1:0] : '0;
			status_q <= info_s1.status;
			fill_q   <= info_s1.fill;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = $signed(popped_q);
	assign rsp.status       = status_q;
	assign rsp.fill_level   = fill_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		launch |-> slot_free)
		else $error("word launched while result stage is blocked");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != STAT_DONE) |-> (popped_q == '0))
		else $error("refused word carries a popped value");

endmodule

// ===== hw/rtl/ring_buffer_deque_core.sv =====
// Ring buffer deque top level: wires pointer logic, entry store and result stage.
// Depends on rbd_pkg, rbd_if, rbd_ctrl, rbd_store and rbd_out.
//
// Usage:
//   req carries one word per operation: action (push front, push back, pop front,
//   pop back) and push_value. rsp returns one word per request, in order:
//   popped_value (0 unless a pop succeeded), status (done, empty, full) and
//   fill_level after the operation. cfg writes the capacity (0 acts as 1, values
//   above DEPTH act as DEPTH) and empties the deque; write it only while idle.
//   An accepted request registers its entry store read and result info in the read
//   stage; the response register then loads from that stage when it is free or taken.
//   Throughput is one word per cycle while rsp does not stall; the single-port entry store
//   takes one access per word, and head and count update in the accept cycle.
//   When rsp stalls, one word waits in the read stage and one in the response
//   register; req.ready drops only when both are held.
//   Reset clears head, count and the pending stages and sets capacity to 16
//   (clipped to DEPTH). Entry contents are not cleared; only pushed slots are read.
module ring_buffer_deque_core import rbd_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic     clk,
	input  logic     arst_n,
	rbd_req_if.sink  req,
	rbd_rsp_if.source rsp,
	rbd_cfg_if.sink  cfg
);

	mem_cmd_t              mem_cmd;
	logic [AW-1:0]         mem_addr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [DATA_WIDTH-1:0] mem_rdata;
	logic                  launch;
	s1_info_t              launch_info;
	logic                  slot_free;

	rbd_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg         (cfg),
		.slot_free   (slot_free),
		.mem_cmd     (mem_cmd),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.launch      (launch),
		.launch_info (launch_info)
	);

	rbd_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	rbd_out #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.launch      (launch),
		.launch_info (launch_info),
		.rdata       (mem_rdata),
		.slot_free   (slot_free),
		.rsp         (rsp)
	);

endmodule

// ===== bench/rbd_deque_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the ring buffer deque: mirrors the deque, predicts every response word
// and compares it with what the core returns. Depends on rbd_pkg and the rbd_if channels.
module rbd_deque_checker import rbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rbd_req_if   req,
	rbd_rsp_if   rsp,
	rbd_cfg_if   cfg,
	output int   errors,
	output int   outstanding
);

	typedef struct packed {
		logic [VAL_W-1:0] value;
		status_t          status;
		logic [CNT_W-1:0] fill;
	} deque_word_t;

	// Mirrored deque state
	logic [VAL_W-1:0] slot_mem [DEPTH_DEF];
	logic [CNT_W-1:0] cap_reg;
	int unsigned      head;
	int unsigned      count;

	deque_word_t      due_words [$];
	deque_word_t      due_w;
	int               err_cnt;

	// Apply one operation to the mirror and return the response word it yields
	function automatic deque_word_t deque_apply(action_t act, logic [VAL_W-1:0] val);
		int unsigned cap;
		int unsigned slot;
		deque_word_t w;
		if (cap_reg == '0) begin
			cap = 1;
		end else if (cap_reg > DEPTH_DEF) begin
			cap = DEPTH_DEF;
		end else begin
			cap = cap_reg;
		end
		if (head >= cap) begin
			head = head % cap;
		end
		if (count > cap) begin
			count = cap;
		end
		w = '0;
		w.status = STAT_DONE;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (count >= cap) begin
					w.status = STAT_FULL;
				end else begin
					if (act == ACT_PUSH_FRONT) begin
						// front grows backward around the ring
						head = (head + cap - 1) % cap;
						slot = head;
					end else begin
						slot = (head + count) % cap;
					end
					slot_mem[slot] = val;
					count++;
				end
			end
			default: begin
				if (count == 0) begin
					w.status = STAT_EMPTY;
				end else if (act == ACT_POP_FRONT) begin
					w.value = slot_mem[head];
					head = (head + 1) % cap;
					count--;
				end else begin
					slot = (head + count - 1) % cap;
					w.value = slot_mem[slot];
					count--;
				end
			end
		endcase
		w.fill = CNT_W'(count);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// drop everything in flight and restore the reset capacity
			cap_reg = CAP_RESET;
			head = 0;
			count = 0;
			due_words.delete();
			outstanding <= 0;
		end else begin
			// capacity write empties the deque
			if (cfg.valid && cfg.ready) begin
				cap_reg = cfg.capacity;
				head = 0;
				count = 0;
			end

			// compare each returned word with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (due_words.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("%0t: response word with nothing pending: value=%h status=%0d fill=%0d",
							$realtime, rsp.popped_value, rsp.status, rsp.fill_level);
					end
				end else begin
					due_w = due_words.pop_front();
					if (rsp.popped_value !== due_w.value || rsp.status !== due_w.status ||
						rsp.fill_level !== due_w.fill) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("%0t: mismatch: expected value=%h status=%0d fill=%0d, got value=%h status=%0d fill=%0d",
								$realtime, due_w.value, due_w.status, due_w.fill,
								rsp.popped_value, rsp.status, rsp.fill_level);
						end
					end
				end
			end

			// predict the word for each accepted request
			if (req.valid && req.ready) begin
				due_words.push_back(deque_apply(action_t'(req.action), req.push_value));
			end

			outstanding <= due_words.size();
			errors <= err_cnt;
		end
	end

endmodule

// ===== bench/ring_buffer_deque_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for ring_buffer_deque_core: drives requests, capacity writes and response
// backpressure, checked by rbd_deque_checker. Depends on it, the core, rbd_pkg, rbd_if.
module ring_buffer_deque_core_tb;
	import rbd_pkg::*;

	localparam int RUN_LIMIT      = 200000;
	localparam int DRAIN_WAIT     = 8;
	localparam int RAND_PER_PHASE = 170;

	logic clk;
	logic arst_n;
	int   snd_gap_pct   = 0;
	int   rcv_stall_pct = 0;
	int   errors;
	int   outstanding;

	rbd_req_if req ();
	rbd_rsp_if rsp ();
	rbd_cfg_if cfg ();

	ring_buffer_deque_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	rbd_deque_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response backpressure: stall at the current rate
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// Hard stop
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// Send one request word, idling beforehand at the current gap rate
	task automatic issue_op(action_t act, logic [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < snd_gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.action     <= act;
		req.push_value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Write capacity once the core has drained
	task automatic set_capacity(logic [CNT_W-1:0] c);
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg.valid    <= 1'b1;
		cfg.capacity <= c;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return VAL_W'($urandom());
		endcase
	endfunction

	// Runs of push-heavy, pop-heavy and balanced traffic to hit full and empty often
	task automatic random_phase(int n_ops);
		int      done_ops;
		int      run_len;
		int      push_pct;
		action_t act;
		done_ops = 0;
		while (done_ops < n_ops) begin
			run_len = $urandom_range(4, 40);
			case ($urandom_range(0, 2))
				0:       push_pct = 85;
				1:       push_pct = 15;
				default: push_pct = 50;
			endcase
			for (int i = 0; i < run_len && done_ops < n_ops; i++) begin
				if ($urandom_range(0, 99) < push_pct) begin
					act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
				end else begin
					act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
				end
				issue_op(act, pick_value());
				done_ops++;
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] phase_caps [6];
		phase_caps = '{5'd17, 5'd4, 5'd1, 5'd16, 5'd31, 5'd6};

		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.action     <= ACT_PUSH_FRONT;
		req.push_value <= '0;
		cfg.valid      <= 1'b0;
		cfg.capacity   <= CAP_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: empty pops, extreme values at both ends
		issue_op(ACT_POP_FRONT, 32'h1234_5678);
		issue_op(ACT_POP_BACK, 32'hFFFF_FFFF);
		issue_op(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
		issue_op(ACT_PUSH_BACK, 32'h8000_0000);
		issue_op(ACT_PUSH_FRONT, 32'h0000_0000);
		issue_op(ACT_PUSH_BACK, 32'hFFFF_FFFF);
		issue_op(ACT_POP_BACK, '0);
		issue_op(ACT_POP_FRONT, '0);
		issue_op(ACT_PUSH_BACK, 32'h5555_AAAA);

		// Capacity zero acts as one; the write also empties the deque
		set_capacity(5'd0);
		issue_op(ACT_POP_FRONT, '0);
		issue_op(ACT_PUSH_BACK, 32'hAAAA_5555);
		issue_op(ACT_PUSH_FRONT, 32'h0000_0001);
		issue_op(ACT_PUSH_BACK, 32'h0000_0002);
		issue_op(ACT_POP_BACK, '0);
		issue_op(ACT_PUSH_FRONT, 32'h1234_5678);
		issue_op(ACT_POP_FRONT, '0);

		// Two slots: wrap the head both ways and refuse a push when full
		set_capacity(5'd2);
		issue_op(ACT_PUSH_FRONT, 32'hA5A5_A5A5);
		issue_op(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
		issue_op(ACT_PUSH_BACK, 32'hDEAD_0001);
		issue_op(ACT_POP_BACK, '0);
		issue_op(ACT_PUSH_BACK, 32'h0F0F_F0F0);
		issue_op(ACT_POP_FRONT, '0);
		issue_op(ACT_POP_FRONT, '0);
		issue_op(ACT_POP_BACK, '0);

		// Random phases: receiver stalls first, then sender idles, then neither
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					snd_gap_pct   = 20;
					rcv_stall_pct = 64;
				end
				1: begin
					snd_gap_pct   = 64;
					rcv_stall_pct = 20;
				end
				default: begin
					snd_gap_pct   = 0;
					rcv_stall_pct = 0;
				end
			endcase
			set_capacity(phase_caps[p]);
			random_phase(RAND_PER_PHASE);
		end

		// Drain and report
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_if.sv
hw/rtl/rbd_store.sv
hw/rtl/rbd_ctrl.sv
hw/rtl/rbd_out.sv
hw/rtl/ring_buffer_deque_core.sv
bench/rbd_deque_checker.sv
bench/ring_buffer_deque_core_tb.sv
